// ===== hdl/bmg_pkg.sv =====
`default_nettype none
package bmg_pkg;

  localparam int CODE_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int SAMPLE_W  = 20;

  // log2 datapath
  localparam int FRAC_W    = 28;
  localparam int LOG_W     = 32;               // Q4.28
  localparam int MANT_W    = 32;               // Q1.31 mantissa
  localparam int LOG_LAT   = FRAC_W + 1;
  localparam int S_W       = 33;               // -2 ln u, Q28

  // square root datapath
  localparam int SQ_IN_W   = S_W + 4;
  localparam int SQ_STEPS  = (SQ_IN_W + 1) / 2;
  localparam int SQ_LAT    = SQ_STEPS + 1;
  localparam int RAD_W     = SQ_STEPS;         // radius, Q16
  localparam int RAD_LAT   = LOG_LAT + 2 + SQ_LAT;

  // trig datapath
  localparam int ANG_W     = 30;               // Q30 angle and x^2
  localparam int Q30_W     = 31;               // holds 1.0 in Q30
  localparam int TRIG_LAT  = 19;

  localparam int SCALE_LAT = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
  localparam logic [30:0]       TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [31:0]       PI_Q30      = 32'd3373259426;
  localparam logic [Q30_W-1:0]  Q30_ONE     = 31'h4000_0000;

  typedef struct packed {
    logic [Q30_W-1:0] cmag;
    logic [Q30_W-1:0] smag;
    logic             cneg;
    logic             sneg;
  } trig_t;

endpackage
`default_nettype wire

// ===== hdl/bmg_delay.sv =====
`default_nettype none
module bmg_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] dly_r [DEPTH];

  always_ff @(posedge clk) begin
    dly_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign dout = dly_r[DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/bmg_log2.sv =====
`default_nettype none
module bmg_log2 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [bmg_pkg::CODE_W-1:0]  in_code,
  output logic                        out_valid,
  output logic [bmg_pkg::S_W-1:0]     out_s
);
  import bmg_pkg::*;

  localparam int PROD_W = 2 * MANT_W;

  // elaboration only: log2 of the full-scale code
  function automatic logic [LOG_W-1:0] log2_q28(input logic [CODE_W-1:0] c);
    logic [3:0]        e;
    logic [63:0]       m;
    logic [FRAC_W-1:0] f;
    e = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (c[i]) e = 4'(i);
    end
    m = 64'(c) << (31 - e);
    f = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 31;
      f = {f[FRAC_W-2:0], m[32]};
      if (m[32]) m = m >> 1;
    end
    return {e, f};
  endfunction

  localparam logic [LOG_W-1:0] LOG_MAX = log2_q28({CODE_W{1'b1}});

  logic [3:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (in_code[i]) lead = 4'(i);
    end
  end

  logic              vld_r  [FRAC_W+1];
  logic [3:0]        exp_r  [FRAC_W+1];
  logic [MANT_W-1:0] mant_r [FRAC_W+1];
  logic [FRAC_W-1:0] frac_r [FRAC_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid && (in_code != '0);
    end
  end

  always_ff @(posedge clk) begin
    exp_r[0]  <= lead;
    mant_r[0] <= MANT_W'(in_code) << (5'd31 - {1'b0, lead});
    frac_r[0] <= '0;
  end

  // one squaring per stage, one fraction bit out
  for (genvar g = 0; g < FRAC_W; g++) begin : g_sq
    logic [PROD_W-1:0] sq;
    logic [MANT_W:0]   sq_top;

    assign sq     = PROD_W'(mant_r[g]) * PROD_W'(mant_r[g]);
    assign sq_top = sq[PROD_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      exp_r[g+1]  <= exp_r[g];
      frac_r[g+1] <= {frac_r[g][FRAC_W-2:0], sq_top[MANT_W]};
      mant_r[g+1] <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
    end
  end

  logic [LOG_W-1:0] lc;
  logic [LOG_W-1:0] d_r;
  logic             d_vld_r;
  logic [62:0]      s_prod;
  logic [S_W-1:0]   s_r;
  logic             s_vld_r;

  assign lc     = {exp_r[FRAC_W], frac_r[FRAC_W]};
  assign s_prod = 63'(d_r) * 63'(TWO_LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      d_vld_r <= vld_r[FRAC_W];
      s_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= (lc > LOG_MAX) ? '0 : LOG_MAX - lc;
    s_r <= s_prod[62:30];
  end

  assign out_valid = s_vld_r;
  assign out_s     = s_r;

endmodule
`default_nettype wire

// ===== hdl/bmg_isqrt.sv =====
`default_nettype none
module bmg_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [bmg_pkg::SQ_IN_W-1:0]  in_n,
  output logic                         out_valid,
  output logic [bmg_pkg::RAD_W-1:0]    out_root
);
  import bmg_pkg::*;

  localparam int ACC_W = SQ_IN_W + 1;

  logic               vld_r  [SQ_STEPS+1];
  logic [SQ_IN_W-1:0] rem_r  [SQ_STEPS+1];
  logic [ACC_W-1:0]   root_r [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= in_n;
    root_r[0] <= '0;
  end

  // one result bit per stage, trial bit falls by a factor of four
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (SQ_STEPS - 1 - g));
    logic [ACC_W-1:0] trial;
    logic [ACC_W-1:0] diff;
    logic             fits;

    assign trial = root_r[g] + BIT;
    assign fits  = {1'b0, rem_r[g]} >= trial;
    assign diff  = {1'b0, rem_r[g]} - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g+1]  <= fits ? diff[SQ_IN_W-1:0] : rem_r[g];
      root_r[g+1] <= fits ? (root_r[g] >> 1) + BIT : root_r[g] >> 1;
    end
  end

  assign out_valid = vld_r[SQ_STEPS];
  assign out_root  = root_r[SQ_STEPS][RAD_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/bmg_horner.sv =====
`default_nettype none
module bmg_horner #(
  parameter int K_DIV = 2
) (
  input  logic                       clk,
  input  logic [bmg_pkg::ANG_W-1:0]  in_x2,
  input  logic [bmg_pkg::Q30_W-1:0]  in_t,
  output logic [bmg_pkg::ANG_W-1:0]  out_x2,
  output logic [bmg_pkg::Q30_W-1:0]  out_t
);
  import bmg_pkg::*;

  // floor(q/K) by reciprocal, low by at most one, fixed in the last stage
  localparam int              SHIFT = 30 + $clog2(K_DIV);
  localparam logic [30:0]     RECIP = 31'((64'd1 << SHIFT) / K_DIV);
  localparam int              QM_W  = ANG_W + 31;
  localparam logic [ANG_W-1:0] KVAL = ANG_W'(K_DIV);

  logic [60:0]      prod;
  logic [ANG_W-1:0] q_a_r, x2_a_r;
  logic [QM_W-1:0]  qm, qm_sh;
  logic [ANG_W-1:0] q_b_r, qe_b_r, x2_b_r;
  logic [ANG_W-1:0] qk, rem, quot;
  logic [Q30_W-1:0] t_r;
  logic [ANG_W-1:0] x2_c_r;

  assign prod  = 61'(in_x2) * 61'(in_t);
  assign qm    = QM_W'(q_a_r) * QM_W'(RECIP);
  assign qm_sh = qm >> SHIFT;
  assign qk    = ANG_W'(qe_b_r * KVAL);
  assign rem   = q_b_r - qk;
  assign quot  = (rem >= KVAL) ? qe_b_r + 1'b1 : qe_b_r;

  always_ff @(posedge clk) begin
    q_a_r  <= prod[59:30];
    x2_a_r <= in_x2;
    q_b_r  <= q_a_r;
    qe_b_r <= qm_sh[ANG_W-1:0];
    x2_b_r <= x2_a_r;
    t_r    <= Q30_ONE - {1'b0, quot};
    x2_c_r <= x2_b_r;
  end

  assign out_x2 = x2_c_r;
  assign out_t  = t_r;

endmodule
`default_nettype wire

// ===== hdl/bmg_trig.sv =====
`default_nettype none
module bmg_trig (
  input  logic                        clk,
  input  logic [bmg_pkg::CODE_W-1:0]  in_code,
  output bmg_pkg::trig_t              out_trig
);
  import bmg_pkg::*;

  logic [31:0]      phase;
  logic [28:0]      low;
  logic [2:0]       oct0_r, oct1_r, oct2_r;
  logic [ANG_W-1:0] a_r, x_r, xd_r, x2_r;
  logic [61:0]      xp;
  logic [59:0]      xx;

  // code * 2^32 / 65535 is the code repeated, full scale wraps to zero
  assign phase = (in_code == {CODE_W{1'b1}}) ? '0 : {in_code, in_code};
  assign low   = phase[28:0];
  assign xp    = 62'(a_r) * 62'(PI_Q30);
  assign xx    = 60'(x_r) * 60'(x_r);

  always_ff @(posedge clk) begin
    oct0_r <= phase[31:29];
    a_r    <= phase[29] ? 30'h2000_0000 - {1'b0, low} : {1'b0, low};
    oct1_r <= oct0_r;
    x_r    <= xp[60:31];
    oct2_r <= oct1_r;
    xd_r   <= x_r;
    x2_r   <= xx[59:30];
  end

  // sine: x * (1 - x2/6 (1 - x2/20 (1 - x2/42 (1 - x2/72))))
  logic [ANG_W-1:0] sx2 [5];
  logic [Q30_W-1:0] st  [5];

  assign sx2[0] = x2_r;
  assign st[0]  = Q30_ONE;

  bmg_horner #(.K_DIV(72)) u_s0 (.clk, .in_x2(sx2[0]), .in_t(st[0]),
                                  .out_x2(sx2[1]), .out_t(st[1]));
  bmg_horner #(.K_DIV(42)) u_s1 (.clk, .in_x2(sx2[1]), .in_t(st[1]),
                                  .out_x2(sx2[2]), .out_t(st[2]));
  bmg_horner #(.K_DIV(20)) u_s2 (.clk, .in_x2(sx2[2]), .in_t(st[2]),
                                  .out_x2(sx2[3]), .out_t(st[3]));
  bmg_horner #(.K_DIV(6))  u_s3 (.clk, .in_x2(sx2[3]), .in_t(st[3]),
                                  .out_x2(sx2[4]), .out_t(st[4]));

  // cosine: 1 - x2/2 (1 - x2/12 (1 - x2/30 (1 - x2/56 (1 - x2/90))))
  logic [ANG_W-1:0] cx2 [6];
  logic [Q30_W-1:0] ct  [6];

  assign cx2[0] = x2_r;
  assign ct[0]  = Q30_ONE;

  bmg_horner #(.K_DIV(90)) u_c0 (.clk, .in_x2(cx2[0]), .in_t(ct[0]),
                                  .out_x2(cx2[1]), .out_t(ct[1]));
  bmg_horner #(.K_DIV(56)) u_c1 (.clk, .in_x2(cx2[1]), .in_t(ct[1]),
                                  .out_x2(cx2[2]), .out_t(ct[2]));
  bmg_horner #(.K_DIV(30)) u_c2 (.clk, .in_x2(cx2[2]), .in_t(ct[2]),
                                  .out_x2(cx2[3]), .out_t(ct[3]));
  bmg_horner #(.K_DIV(12)) u_c3 (.clk, .in_x2(cx2[3]), .in_t(ct[3]),
                                  .out_x2(cx2[4]), .out_t(ct[4]));
  bmg_horner #(.K_DIV(2))  u_c4 (.clk, .in_x2(cx2[4]), .in_t(ct[4]),
                                  .out_x2(cx2[5]), .out_t(ct[5]));

  logic [ANG_W-1:0] x_late;
  logic [2:0]       oct_late;
  logic [60:0]      sp;
  logic [Q30_W-1:0] sn_r, sn_late;
  trig_t            trig_r;

  bmg_delay #(.WIDTH(ANG_W), .DEPTH(12)) u_xdly (.clk, .din(xd_r), .dout(x_late));
  bmg_delay #(.WIDTH(3), .DEPTH(15)) u_odly (.clk, .din(oct2_r), .dout(oct_late));

  assign sp = 61'(x_late) * 61'(st[4]);

  always_ff @(posedge clk) begin
    sn_r <= sp[60:30];
  end

  bmg_delay #(.WIDTH(Q30_W), .DEPTH(2)) u_sdly (.clk, .din(sn_r), .dout(sn_late));

  // octant folding
  always_ff @(posedge clk) begin
    trig_r.cmag <= (oct_late[0] ^ oct_late[1]) ? sn_late : ct[5];
    trig_r.smag <= (oct_late[0] ^ oct_late[1]) ? ct[5] : sn_late;
    trig_r.cneg <= oct_late[2] ^ oct_late[1];
    trig_r.sneg <= oct_late[2];
  end

  assign out_trig = trig_r;

endmodule
`default_nettype wire

// ===== hdl/bmg_scale.sv =====
`default_nettype none
module bmg_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [bmg_pkg::RAD_W-1:0]           in_radius,
  input  bmg_pkg::trig_t                      in_trig,
  input  logic [bmg_pkg::GAIN_W-1:0]          in_gain,
  output logic                                out_valid,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] out_cos,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] out_sin
);
  import bmg_pkg::*;

  localparam int P_W   = RAD_W + Q30_W;   // 50
  localparam int PS_W  = P_W - 14;        // 36
  localparam int G_W   = PS_W + GAIN_W + 1;
  localparam int MAG_W = G_W - 32;        // 21

  function automatic logic [SAMPLE_W-1:0] sat(input logic [MAG_W-1:0] mag,
                                              input logic neg);
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] nv;
    if (neg) begin
      lim = (mag > MAG_W'(21'h80000)) ? MAG_W'(21'h80000) : mag;
      nv  = MAG_W'(0) - lim;
      return nv[SAMPLE_W-1:0];
    end
    lim = (mag > MAG_W'(21'h7FFFF)) ? MAG_W'(21'h7FFFF) : mag;
    return lim[SAMPLE_W-1:0];
  endfunction

  logic [P_W-1:0]   pc, ps;
  logic [PS_W-1:0]  pc_r, ps_r;
  logic [G_W-1:0]   gc, gs;
  logic [MAG_W-1:0] mc_r, ms_r;
  logic             cneg1_r, sneg1_r, cneg2_r, sneg2_r;
  logic             v1_r, v2_r, v3_r;
  logic [SAMPLE_W-1:0] c_r, s_r;

  assign pc = P_W'(in_radius) * P_W'(in_trig.cmag);
  assign ps = P_W'(in_radius) * P_W'(in_trig.smag);
  assign gc = G_W'(pc_r) * G_W'(in_gain) + (G_W'(1) << 31);
  assign gs = G_W'(ps_r) * G_W'(in_gain) + (G_W'(1) << 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    pc_r    <= pc[P_W-1:14];
    ps_r    <= ps[P_W-1:14];
    cneg1_r <= in_trig.cneg;
    sneg1_r <= in_trig.sneg;
    mc_r    <= gc[G_W-1:32];
    ms_r    <= gs[G_W-1:32];
    cneg2_r <= cneg1_r;
    sneg2_r <= sneg1_r;
    c_r     <= sat(mc_r, cneg2_r);
    s_r     <= sat(ms_r, sneg2_r);
  end

  assign out_valid = v3_r;
  assign out_cos   = c_r;
  assign out_sin   = s_r;

endmodule
`default_nettype wire

// ===== hdl/box_muller_gaussian_noise.sv =====
`default_nettype none
// Channel   | Ports                                              | Transaction
// ----------+----------------------------------------------------+------------------------------
// input     | start, busy, in_uniform_radius_code/angle_code     | start high while busy low
// result    | out_valid, out_normal_cos_sample/sin_sample        | out_valid high, one cycle
// config    | cfg_wr_en, cfg_wr_data                             | cfg_wr_en high, no wait
//
// One transaction per clock; busy is never raised. The result path runs through
// 29 log2 stages, 2 stages for -2 ln u, 20 square-root stages and 3 scaling
// stages. The trig path (19 stages) is delayed to match.
// rst_n is synchronous and clears the valid pipeline and sets the gain to 1.0.
// The receiver cannot stall; a radius code of zero drops its transaction.
module box_muller_gaussian_noise (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bmg_pkg::CODE_W-1:0]          in_uniform_radius_code,
  input  logic [bmg_pkg::CODE_W-1:0]          in_uniform_angle_code,
  input  logic                                cfg_wr_en,
  input  logic [bmg_pkg::GAIN_W-1:0]          cfg_wr_data,
  output logic                                out_valid,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] out_normal_cos_sample,
  output logic signed [bmg_pkg::SAMPLE_W-1:0] out_normal_sin_sample
);
  import bmg_pkg::*;

  localparam int ALIGN = RAD_LAT - TRIG_LAT;
  localparam int LAT   = RAD_LAT + SCALE_LAT;
  localparam int TW    = $bits(trig_t);

  // gain register, to be written only while idle; the block itself does not enforce this
  logic [GAIN_W-1:0] noise_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      noise_gain_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // radius path: log2, -2 ln u, square root
  logic           s_vld;
  logic [S_W-1:0] s_val;
  logic           r_vld;
  logic [RAD_W-1:0] radius;

  bmg_log2 u_log2 (
    .clk, .rst_n,
    .in_valid  (start),
    .in_code   (in_uniform_radius_code),
    .out_valid (s_vld),
    .out_s     (s_val)
  );

  bmg_isqrt u_isqrt (
    .clk, .rst_n,
    .in_valid  (s_vld),
    .in_n      ({s_val, 4'b0}),
    .out_valid (r_vld),
    .out_root  (radius)
  );

  // angle path: octant fold and Taylor series, then aligned with the radius
  trig_t          trig_early, trig_late;
  logic [TW-1:0]  trig_bits;

  bmg_trig u_trig (
    .clk,
    .in_code  (in_uniform_angle_code),
    .out_trig (trig_early)
  );

  bmg_delay #(.WIDTH(TW), .DEPTH(ALIGN)) u_align (
    .clk,
    .din  (trig_early),
    .dout (trig_bits)
  );

  assign trig_late = trig_t'(trig_bits);

  bmg_scale u_scale (
    .clk, .rst_n,
    .in_valid  (r_vld),
    .in_radius (radius),
    .in_trig   (trig_late),
    .in_gain   (noise_gain_r),
    .out_valid (out_valid),
    .out_cos   (out_normal_cos_sample),
    .out_sin   (out_normal_sin_sample)
  );

  // every result traces back to an accepted transaction with a nonzero radius code
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n && start && (in_uniform_radius_code != '0), LAT))
    else $error("result without a matching input transaction");

  // zero gain forces both samples to zero
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (noise_gain_r == '0)) |->
      (out_normal_cos_sample == '0) && (out_normal_sin_sample == '0))
    else $error("nonzero sample with zero gain");

endmodule
`default_nettype wire
